FILE: sv/lsag_pkg.sv
package lsag_pkg;

  localparam int POS_W = 32;
  localparam int STEP_W = 31;
  localparam int CELL_W = 10;
  localparam int FLAT_W = 30;
  localparam int NUM_W = 34;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 33;
  localparam int COUNT_LIMIT = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTS = 3'd6;

  typedef logic [CELL_W-1:0] cell_t;

  typedef struct packed {
    cell_t lo_x;
    cell_t hi_x;
    cell_t lo_y;
    cell_t hi_y;
    cell_t lo_z;
    cell_t hi_z;
    logic  cut;
  } box_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_t;

endpackage

FILE: sv/lsag_divider.sv
module lsag_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [lsag_pkg::NUM_W-1:0] num,
  input  logic [lsag_pkg::STEP_W-1:0]     den,
  output logic                            done,
  output logic signed [lsag_pkg::NUM_W-1:0] quot
);
  import lsag_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]   rem_mag;
  logic [NUM_W-1:0]   q;
  logic [STEP_W:0]    r;
  logic [STEP_W-1:0]  d;
  logic               neg;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [STEP_W+1:0]  trial;
  logic [STEP_W+1:0]  diff;

  always_comb begin
    trial = {r, rem_mag[NUM_W-1]};
    diff = trial - {2'b00, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(NUM_W);
        neg <= num[NUM_W-1];
        rem_mag <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        d <= (den == '0) ? STEP_W'(1) : den;
        r <= '0;
        q <= '0;
      end else if (busy) begin
        rem_mag <= {rem_mag[NUM_W-2:0], 1'b0};
        if (!diff[STEP_W+1]) begin
          r <= diff[STEP_W:0];
          q <= {q[NUM_W-2:0], 1'b1};
        end else begin
          r <= trial[STEP_W:0];
          q <= {q[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? -$signed(q) : $signed(q);

endmodule

FILE: sv/lsag_front.sv
module lsag_front #(
  parameter int MAX_SPAN = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [lsag_pkg::POS_W-1:0] pos [3],
  input  logic [lsag_pkg::STEP_W-1:0]       reach [3],
  input  logic signed [lsag_pkg::POS_W-1:0] origin [3],
  input  logic [lsag_pkg::STEP_W-1:0]       spacing [3],
  input  logic [lsag_pkg::CELL_W:0]         count [3],
  output logic                              box_valid,
  input  logic                              box_full,
  output lsag_pkg::box_t                    box
);
  import lsag_pkg::*;

  front_state_t state, state_next;
  logic [2:0] step, step_next;
  logic signed [POS_W-1:0] pos_r [3];
  logic [STEP_W-1:0] reach_r [3];
  cell_t lo [3];
  cell_t hi [3];
  logic cut;
  logic div_start, div_done, issue;
  logic signed [NUM_W-1:0] div_num, quot;
  logic [STEP_W-1:0] div_den;
  logic [1:0] ax;
  logic signed [NUM_W-1:0] qv, nm1;
  cell_t cv;
  logic [CELL_W:0] span;

  assign ax = step[2:1];
  assign div_start = issue;

  always_comb begin
    div_num = step[0]
      ? NUM_W'(pos_r[ax]) + NUM_W'($signed({1'b0, reach_r[ax]})) - NUM_W'(origin[ax])
      : NUM_W'(pos_r[ax]) - NUM_W'($signed({1'b0, reach_r[ax]})) - NUM_W'(origin[ax]);
    div_den = spacing[ax];
    qv = step[0] ? quot + NUM_W'(1) : quot;
    nm1 = $signed(NUM_W'(count[ax])) - NUM_W'(1);
    if (qv > nm1) qv = nm1;
    if (qv < 0) qv = '0;
    cv = CELL_W'(qv);
    span = (cv < lo[ax]) ? '0 : {1'b0, cv - lo[ax]};
  end

  lsag_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
      step <= '0;
    end else begin
      state <= state_next;
      step <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next = step;
    in_stall = (state != FR_IDLE);
    box_valid = (state == FR_PUSH);
    unique case (state)
      FR_IDLE: begin
        if (in_valid) begin
          state_next = FR_DIV;
          step_next = '0;
        end
      end
      FR_DIV: begin
        if (div_done) begin
          if (step == 3'd5) state_next = FR_PUSH;
          else step_next = step + 3'd1;
        end
      end
      FR_PUSH: begin
        if (!box_full) state_next = FR_IDLE;
      end
      default: state_next = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue <= 1'b0;
    end else begin
      issue <= (state == FR_IDLE && in_valid) ||
               (state == FR_DIV && div_done && step != 3'd5);
    end
  end

  always_ff @(posedge clk) begin
    if (state == FR_IDLE && in_valid) begin
      pos_r <= pos;
      reach_r <= reach;
      cut <= 1'b0;
    end
    if (state == FR_DIV && div_done) begin
      if (!step[0]) begin
        lo[ax] <= cv;
      end else begin
        if (span >= (CELL_W+1)'(MAX_SPAN)) begin
          hi[ax] <= lo[ax] + CELL_W'(MAX_SPAN - 1);
          cut <= 1'b1;
        end else if (cv < lo[ax]) begin
          hi[ax] <= lo[ax];
        end else begin
          hi[ax] <= cv;
        end
      end
    end
  end

  always_comb begin
    box.lo_x = lo[0]; box.hi_x = hi[0];
    box.lo_y = lo[1]; box.hi_y = hi[1];
    box.lo_z = lo[2]; box.hi_z = hi[2];
    box.cut = cut;
  end

endmodule

FILE: sv/lsag_queue.sv
module lsag_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  lsag_pkg::box_t wdata,
  output logic           full,
  input  logic           rd,
  output logic           empty,
  output lsag_pkg::box_t rdata
);
  import lsag_pkg::*;

  box_t mem [2];
  logic wp, rp;
  logic [1:0] fill;

  assign full = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= '0;
    end else begin
      if (wr && !full) begin
        mem[wp] <= wdata;
        wp <= ~wp;
      end
      if (rd && !empty) rp <= ~rp;
      fill <= fill + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
    end
  end

endmodule

FILE: sv/lsag_back.sv
module lsag_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  lsag_pkg::box_t                    q_box,
  output logic                              q_rd,
  input  logic signed [lsag_pkg::POS_W-1:0] origin [3],
  input  logic [lsag_pkg::STEP_W-1:0]       spacing [3],
  input  logic [lsag_pkg::CELL_W:0]         count [3],
  output logic                              out_valid,
  input  logic                              out_stall,
  output lsag_pkg::cell_t                   lat_idx [3],
  output logic [lsag_pkg::FLAT_W-1:0]       flat_index,
  output logic signed [lsag_pkg::POS_W-1:0] sample [3],
  output logic                              span_cut,
  output logic                              last
);
  import lsag_pkg::*;

  localparam int ACC_W = POS_W + CELL_W + 2;

  box_t b;
  logic active;
  cell_t ix, iy, iz;
  logic [FLAT_W-1:0] row_z, row_y;
  logic signed [ACC_W-1:0] pz, py, px;
  logic end_x, end_y, end_z, load, adv;
  logic [FLAT_W-1:0] plane;

  assign end_x = (ix == b.hi_x);
  assign end_y = (iy == b.hi_y);
  assign end_z = (iz == b.hi_z);
  assign load = !active && !q_empty;
  assign adv = active && (!out_valid || !out_stall);
  assign q_rd = load;

  function automatic logic signed [POS_W-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-POS_W:0] top;
    top = v[ACC_W-1:POS_W-1];
    if (top == '0 || top == '1) return v[POS_W-1:0];
    return v[ACC_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
  endfunction

  always_ff @(posedge clk) begin
    plane <= FLAT_W'(count[0] * count[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= adv || (out_valid && out_stall);
      if (load) begin
        b <= q_box;
        active <= 1'b1;
        ix <= q_box.lo_x; iy <= q_box.lo_y; iz <= q_box.lo_z;
        row_z <= FLAT_W'(q_box.lo_z * plane);
        row_y <= FLAT_W'(q_box.lo_y * count[0]);
        px <= ACC_W'(origin[0]) + ACC_W'(q_box.lo_x * spacing[0]);
        py <= ACC_W'(origin[1]) + ACC_W'(q_box.lo_y * spacing[1]);
        pz <= ACC_W'(origin[2]) + ACC_W'(q_box.lo_z * spacing[2]);
      end else if (adv) begin
        lat_idx[0] <= ix; lat_idx[1] <= iy; lat_idx[2] <= iz;
        flat_index <= row_z + row_y + FLAT_W'(ix);
        sample[0] <= sat(px); sample[1] <= sat(py); sample[2] <= sat(pz);
        span_cut <= b.cut;
        last <= end_x && end_y && end_z;
        if (!end_x) begin
          ix <= ix + 1'b1;
          px <= px + ACC_W'(spacing[0]);
        end else begin
          ix <= b.lo_x;
          px <= ACC_W'(origin[0]) + ACC_W'(b.lo_x * spacing[0]);
          if (!end_y) begin
            iy <= iy + 1'b1;
            row_y <= row_y + FLAT_W'(count[0]);
            py <= py + ACC_W'(spacing[1]);
          end else begin
            iy <= b.lo_y;
            row_y <= FLAT_W'(b.lo_y * count[0]);
            py <= ACC_W'(origin[1]) + ACC_W'(b.lo_y * spacing[1]);
            if (!end_z) begin
              iz <= iz + 1'b1;
              row_z <= row_z + plane;
              pz <= pz + ACC_W'(spacing[2]);
            end else begin
              active <= 1'b0;
            end
          end
        end
      end
    end
  end

endmodule

FILE: sv/lattice_stencil_address_generator.sv
// Six serial divisions per particle; in_stall blocks the next until its box is queued.
// Back end loads a box from the queue, then emits one lattice point per unstalled cycle.
// Reset: rst synchronous, active high; clears control and restores register defaults.
module lattice_stencil_address_generator #(
  parameter int MAX_SPAN = 4,
  parameter int COUNT_BITS = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [32:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [30:0] reach_x,
  input  logic [30:0] reach_y,
  input  logic [30:0] reach_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  cell_x,
  output logic [9:0]  cell_y,
  output logic [9:0]  cell_z,
  output logic [29:0] flat_index,
  output logic signed [31:0] sample_x,
  output logic signed [31:0] sample_y,
  output logic signed [31:0] sample_z,
  output logic        span_cut,
  output logic        last
);
  import lsag_pkg::*;

  logic signed [POS_W-1:0] origin [3];
  logic [STEP_W-1:0] spacing [3];
  logic [3*COUNT_BITS-1:0] counts;
  logic [CELL_W:0] count [3];
  logic signed [POS_W-1:0] pos [3];
  logic [STEP_W-1:0] reach [3];
  logic signed [POS_W-1:0] sample [3];
  cell_t lat_idx [3];
  logic box_valid, box_full, q_empty, q_rd;
  box_t box, q_box;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0] <= '0; origin[1] <= '0; origin[2] <= '0;
      spacing[0] <= STEP_W'(65536); spacing[1] <= STEP_W'(65536);
      spacing[2] <= STEP_W'(65536);
      counts <= {3{COUNT_BITS'(1)}};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin[0] <= cfg_data[31:0];
        REG_ORIGIN_Y: origin[1] <= cfg_data[31:0];
        REG_ORIGIN_Z: origin[2] <= cfg_data[31:0];
        REG_SPACING_X: spacing[0] <= cfg_data[30:0];
        REG_SPACING_Y: spacing[1] <= cfg_data[30:0];
        REG_SPACING_Z: spacing[2] <= cfg_data[30:0];
        REG_COUNTS: counts <= (3*COUNT_BITS)'(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [COUNT_BITS-1:0] c;
      c = counts[a*COUNT_BITS +: COUNT_BITS];
      if (c == '0) count[a] = (CELL_W+1)'(1);
      else if ({{(32-COUNT_BITS){1'b0}}, c} > 32'(COUNT_LIMIT))
        count[a] = (CELL_W+1)'(COUNT_LIMIT);
      else count[a] = (CELL_W+1)'(c);
    end
  end

  assign pos[0] = pos_x; assign pos[1] = pos_y; assign pos[2] = pos_z;
  assign reach[0] = reach_x; assign reach[1] = reach_y; assign reach[2] = reach_z;

  lsag_front #(.MAX_SPAN(MAX_SPAN)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .pos(pos), .reach(reach), .origin(origin), .spacing(spacing), .count(count),
    .box_valid(box_valid), .box_full(box_full), .box(box)
  );

  lsag_queue u_queue (
    .clk(clk), .rst(rst), .wr(box_valid), .wdata(box), .full(box_full),
    .rd(q_rd), .empty(q_empty), .rdata(q_box)
  );

  lsag_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_box(q_box), .q_rd(q_rd),
    .origin(origin), .spacing(spacing), .count(count),
    .out_valid(out_valid), .out_stall(out_stall), .lat_idx(lat_idx),
    .flat_index(flat_index), .sample(sample), .span_cut(span_cut), .last(last)
  );

  assign cell_x = lat_idx[0]; assign cell_y = lat_idx[1]; assign cell_z = lat_idx[2];
  assign sample_x = sample[0]; assign sample_y = sample[1]; assign sample_z = sample[2];

endmodule
